FILE: src/rlmp_pkg.sv
// ----------------------------------------------------------------------------
// rlmp_pkg
// Shared types, codes and constants of the run-length map parser.
// ----------------------------------------------------------------------------
package rlmp_pkg;

    // Default largest canvas side that a header may declare
    localparam int SIDE_MAX_DEF = 4096;

    // Configuration register widths
    localparam int SIDE_W = 13;
    localparam int PAL_W  = 8;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PAL_COUNT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SIDE_W-1:0] MAP_WIDTH_RST  = 13'd1;
    localparam logic [SIDE_W-1:0] MAP_HEIGHT_RST = 13'd1;
    localparam logic [PAL_W-1:0]  PAL_COUNT_RST  = 8'd16;

    // Result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // File signature, first byte first
    localparam logic [7:0] MAGIC_BYTES [8] = '{
        8'h50, 8'h57, 8'h52, 8'h4D, 8'h41, 8'h50, 8'h31, 8'h00
    };

    // Result kinds
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_COLOR     = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_SHORT     = 3'd6
    } rlmp_status_e;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_WIDTH   = 4'd1,
        PH_HEIGHT  = 4'd2,
        PH_SEQ     = 4'd3,
        PH_PALETTE = 4'd4,
        PH_RUNS    = 4'd5,
        PH_RUNCOL  = 4'd6,
        PH_RUNCNT  = 4'd7,
        PH_DONE    = 4'd8
    } rlmp_phase_e;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } rlmp_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  run_color;
        logic [31:0] run_length;
        logic [63:0] loaded_sequence;
        logic [2:0]  status;
        logic        last;
    } rlmp_out_t;

    typedef struct packed {
        logic [SIDE_W-1:0] map_width;
        logic [SIDE_W-1:0] map_height;
        logic [PAL_W-1:0]  pal_count;
    } rlmp_cfg_t;

    // Up to two results made by one byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        rlmp_out_t  first;
        rlmp_out_t  second;
    } rlmp_push_t;

endpackage

FILE: src/rlmp_parser.sv
// ----------------------------------------------------------------------------
// rlmp_parser
// Parse state machine: consumes one registered byte per cycle while the
// result queue has room, and produces up to two results (run and/or status).
// ----------------------------------------------------------------------------
module rlmp_parser import rlmp_pkg::*; #(
    parameter int SIDE_MAX = SIDE_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  rlmp_in_t   beat,
    input  rlmp_cfg_t  cfg,
    output rlmp_push_t push
);

    // Largest side the registers can hold and still pass the side check
    localparam int SideCap = (SIDE_MAX < (1 << SIDE_W) - 1) ? SIDE_MAX : (1 << SIDE_W) - 1;
    localparam int AreaW   = $clog2(SideCap * SideCap + 1);
    localparam logic [16:0] SideMax = 17'(SIDE_MAX);

    rlmp_phase_e            phase_reg, phase_next;
    logic [2:0]             pos_reg, pos_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   mism_reg, mism_next;
    logic [63:0]            seq_reg, seq_next;
    logic [31:0]            runs_reg, runs_next;
    logic [AreaW-1:0]       pixels_reg, pixels_next;
    logic [7:0]             color_reg, color_next;
    logic [AreaW-1:0]       area_reg;

    logic                   width_ok, height_ok;
    logic [2*SIDE_W-1:0]    area_full;
    logic [63:0]            acc_new;
    logic                   field_end;
    logic                   is_short_field;
    logic                   mism_now;
    logic [32:0]            pixel_sum;
    logic [AreaW-1:0]       pixels_add;
    logic                   run_v;
    logic                   st_v;
    rlmp_status_e           st_code;
    rlmp_out_t              run_res, st_res;

    // Side checks and canvas area; the user must change config only while idle, the block does not enforce it
    assign width_ok  = (cfg.map_width != '0)  && ({4'd0, cfg.map_width}  <= SideMax);
    assign height_ok = (cfg.map_height != '0) && ({4'd0, cfg.map_height} <= SideMax);
    assign area_full = cfg.map_width * cfg.map_height;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_reg <= '0;
        end else begin
            area_reg <= (width_ok && height_ok) ? area_full[AreaW-1:0] : '0;
        end
    end

    // Little-endian field assembly
    assign acc_new = (pos_reg == 3'd0) ? {56'd0, beat.data_byte}
                   : acc_reg | ({56'd0, beat.data_byte} << {pos_reg, 3'b000});
    assign is_short_field = (phase_reg == PH_PALETTE) || (phase_reg == PH_RUNS)
                         || (phase_reg == PH_RUNCNT);
    assign field_end = is_short_field ? (pos_reg == 3'd3) : (pos_reg == 3'd7);
    assign mism_now  = mism_reg || (beat.data_byte != MAGIC_BYTES[pos_reg]);
    assign pixel_sum = 33'(pixels_reg) + {1'b0, acc_new[31:0]};
    assign pixels_add = pixel_sum[AreaW-1:0];

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= '0;
            acc_reg    <= '0;
            mism_reg   <= 1'b0;
            seq_reg    <= '0;
            runs_reg   <= '0;
            pixels_reg <= '0;
            color_reg  <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            mism_reg   <= mism_next;
            seq_reg    <= seq_next;
            runs_reg   <= runs_next;
            pixels_reg <= pixels_next;
            color_reg  <= color_next;
        end
    end

    // Next state and results for the current beat
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        mism_next   = mism_reg;
        seq_next    = seq_reg;
        runs_next   = runs_reg;
        pixels_next = pixels_reg;
        color_next  = color_reg;
        run_v       = 1'b0;
        st_v        = 1'b0;
        st_code     = ST_OK;

        // Shift the byte into the open field
        if (((phase_reg >= PH_WIDTH) && (phase_reg <= PH_RUNS)) || (phase_reg == PH_RUNCNT)) begin
            acc_next = acc_new;
            pos_next = field_end ? 3'd0 : pos_reg + 3'd1;
        end

        unique case (phase_reg)
            PH_MAGIC: begin
                mism_next = mism_now;
                if (pos_reg == 3'd7) begin
                    pos_next = 3'd0;
                    if (mism_now) begin
                        st_v    = 1'b1;
                        st_code = ST_BAD_MAGIC;
                    end else begin
                        phase_next = PH_WIDTH;
                    end
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            PH_WIDTH: begin
                if (field_end) begin
                    if (!width_ok || (acc_new != {51'd0, cfg.map_width})) begin
                        mism_next = 1'b1;
                    end
                    phase_next = PH_HEIGHT;
                end
            end
            PH_HEIGHT: begin
                if (field_end) begin
                    if (!height_ok || (acc_new != {51'd0, cfg.map_height})) begin
                        mism_next = 1'b1;
                    end
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ: begin
                if (field_end) begin
                    seq_next   = acc_new;
                    phase_next = PH_PALETTE;
                end
            end
            PH_PALETTE: begin
                if (field_end) begin
                    if ((cfg.pal_count == '0) || (acc_new != {56'd0, cfg.pal_count})) begin
                        mism_next = 1'b1;
                    end
                    phase_next = PH_RUNS;
                end
            end
            PH_RUNS: begin
                if (field_end) begin
                    runs_next = acc_new[31:0];
                    if (mism_reg) begin
                        st_v    = 1'b1;
                        st_code = ST_MISMATCH;
                    end else if (acc_new[31:0] == '0) begin
                        st_v    = 1'b1;
                        st_code = (pixels_reg == area_reg) ? ST_OK : ST_SHORT;
                    end else begin
                        phase_next = PH_RUNCOL;
                    end
                end
            end
            PH_RUNCOL: begin
                color_next = beat.data_byte;
                pos_next   = 3'd0;
                phase_next = PH_RUNCNT;
            end
            PH_RUNCNT: begin
                if (field_end) begin
                    if (color_reg >= cfg.pal_count) begin
                        st_v    = 1'b1;
                        st_code = ST_COLOR;
                    end else if (pixel_sum > 33'(area_reg)) begin
                        st_v    = 1'b1;
                        st_code = ST_OVERFLOW;
                    end else begin
                        run_v       = 1'b1;
                        pixels_next = pixels_add;
                        runs_next   = runs_reg - 32'd1;
                        if (runs_reg == 32'd1) begin
                            st_v    = 1'b1;
                            st_code = (pixels_add == area_reg) ? ST_OK : ST_SHORT;
                        end else begin
                            phase_next = PH_RUNCOL;
                        end
                    end
                end
            end
            default: begin
                // Decided: drop bytes until the final flag
            end
        endcase

        // Any status other than truncation closes the file
        if (st_v) begin
            phase_next = PH_DONE;
        end

        // Final byte: report truncation if still open, then start over
        if (beat.final_byte) begin
            if (phase_next != PH_DONE) begin
                st_v    = 1'b1;
                st_code = ST_TRUNCATED;
            end
            phase_next  = PH_MAGIC;
            pos_next    = '0;
            acc_next    = '0;
            mism_next   = 1'b0;
            seq_next    = '0;
            runs_next   = '0;
            pixels_next = '0;
            color_next  = '0;
        end
    end

    // Build result records
    always_comb begin
        run_res                 = '0;
        run_res.kind            = KIND_RUN;
        run_res.run_color       = color_reg;
        run_res.run_length      = acc_new[31:0];

        st_res                  = '0;
        st_res.kind             = KIND_STATUS;
        st_res.status           = st_code;
        st_res.loaded_sequence  = (st_code == ST_OK) ? seq_reg : 64'd0;
        st_res.last             = 1'b1;

        push.count  = {1'b0, run_v} + {1'b0, st_v};
        push.first  = run_v ? run_res : st_res;
        push.second = st_res;
    end

endmodule

FILE: src/rlmp_result_fifo.sv
// ----------------------------------------------------------------------------
// rlmp_result_fifo
// Small result queue: takes up to two results a cycle, delivers one beat a
// cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module rlmp_result_fifo import rlmp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_en,
    input  rlmp_push_t push,
    output logic       space_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output rlmp_out_t  m_data
);

    rlmp_out_t              entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic [1:0]             push_n;
    logic                   pop;

    assign push_n   = push_en ? push.count : 2'd0;
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = entry_reg[rd_ptr_reg];
    // Room for the worst case of one beat
    assign space_ok = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign count_next = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // Store results in order
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.second;
        end
    end

endmodule

FILE: src/run_length_map_parser_unit.sv
// ----------------------------------------------------------------------------
// run_length_map_parser_unit
// Checks a run-length pixel-map file arriving one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one file byte per beat, final_byte set on the last byte.
//   m_ channel: run results (kind 0) as each run record completes, then one
//   status result (kind 1, last set) per file. A failed status means the
//   runs already delivered for that file must be dropped by the receiver.
//   cfg port: write map_width, map_height and the palette count while idle.
// Throughput: one byte per cycle. A byte that yields a run and a status needs
//   two output beats; a four-entry result queue absorbs them, so input only
//   slows when the receiver stalls.
// Path: a taken byte is held in the input register, the parse logic decodes
//   it, and its results are written to the result queue, which offers them.
// Reset: parser returns to the magic phase, queue empties, registers take
//   1, 1 and 16. A stalled receiver fills the queue, then s_ready drops.
// ----------------------------------------------------------------------------
module run_length_map_parser_unit import rlmp_pkg::*; #(
    parameter int SIDE_MAX = SIDE_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rlmp_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rlmp_out_t         m_data,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    rlmp_cfg_t  cfg_reg;
    logic       in_valid_reg;
    rlmp_in_t   in_data_reg;
    logic       space_ok;
    logic       fire;
    rlmp_push_t push;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_width  <= MAP_WIDTH_RST;
            cfg_reg.map_height <= MAP_HEIGHT_RST;
            cfg_reg.pal_count  <= PAL_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_data[SIDE_W-1:0];
                CFG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data[SIDE_W-1:0];
                CFG_PAL_COUNT:  cfg_reg.pal_count  <= cfg_data[PAL_W-1:0];
                default: begin
                    // Unused index: drop the write
                end
            endcase
        end
    end

    // Input register: refill whenever it is empty or the held beat is consumed
    assign fire    = in_valid_reg && space_ok;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    rlmp_parser #(
        .SIDE_MAX(SIDE_MAX)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .beat    (in_data_reg),
        .cfg     (cfg_reg),
        .push    (push)
    );

    rlmp_result_fifo u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (fire),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: tb/rlmp_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmp_stream_checker
// Watches the byte, result and register ports of the run-length map parser.
// It keeps its own copy of the parse state and the registers, predicts the
// result beats of every accepted byte, and compares each delivered result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rlmp_stream_checker import rlmp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  rlmp_in_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rlmp_out_t         m_data,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                fail_count,
    output int                due_count,
    output int                beats_checked
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copies of the registers
    logic [SIDE_W-1:0] exp_width;
    logic [SIDE_W-1:0] exp_height;
    logic [PAL_W-1:0]  exp_palette;

    // Parse state of the file in flight
    rlmp_phase_e phase;
    logic [2:0]  field_pos;
    logic [63:0] field_acc;
    logic        hdr_bad;
    logic [63:0] seq_held;
    logic [31:0] runs_left;
    logic [63:0] pixels_total;
    logic [7:0]  color_held;

    rlmp_out_t map_records_due [$];
    int fails   = 0;
    int checked = 0;

    function automatic logic side_ok(input logic [SIDE_W-1:0] v);
        return (v >= 1) && (v <= SIDE_MAX_DEF);
    endfunction

    function automatic logic [63:0] canvas_area();
        if (!side_ok(exp_width) || !side_ok(exp_height))
            return 64'd0;
        return 64'(exp_width) * 64'(exp_height);
    endfunction

    task automatic clear_parse();
        phase        = PH_MAGIC;
        field_pos    = '0;
        field_acc    = '0;
        hdr_bad      = 1'b0;
        seq_held     = '0;
        runs_left    = '0;
        pixels_total = '0;
        color_held   = '0;
    endtask

    task automatic push_status(input rlmp_status_e st);
        rlmp_out_t r;
        r = '0;
        r.kind            = KIND_STATUS;
        r.loaded_sequence = (st == ST_OK) ? seq_held : 64'd0;
        r.status          = st;
        r.last            = 1'b1;
        map_records_due.insert(map_records_due.size(), r);
    endtask

    task automatic push_total_status();
        push_status((pixels_total == canvas_area()) ? ST_OK : ST_SHORT);
    endtask

    // Advance the parse by one byte and queue the results it causes
    task automatic parse_map_byte(input logic [7:0] b, input logic fin);
        int          flen;
        logic        field_end;
        logic        decided;
        logic [63:0] want;
        logic [31:0] cnt;
        rlmp_out_t   r;
        field_end = 1'b0;
        decided   = 1'b0;
        flen = (phase == PH_PALETTE || phase == PH_RUNS || phase == PH_RUNCNT) ? 4 : 8;

        // gather little-endian field bytes
        if ((phase >= PH_WIDTH && phase <= PH_RUNS) || phase == PH_RUNCNT) begin
            if (field_pos == 0)
                field_acc = 64'(b);
            else
                field_acc = field_acc | (64'(b) << (8 * field_pos));
            if (int'(field_pos) + 1 >= flen) begin
                field_end = 1'b1;
                field_pos = '0;
            end else begin
                field_pos = field_pos + 3'd1;
            end
        end

        case (phase)
            PH_MAGIC: begin
                if (b != MAGIC_BYTES[field_pos])
                    hdr_bad = 1'b1;
                if (field_pos == 3'd7) begin
                    field_pos = '0;
                    if (hdr_bad) begin
                        push_status(ST_BAD_MAGIC);
                        decided = 1'b1;
                    end else begin
                        phase = PH_WIDTH;
                    end
                end else begin
                    field_pos = field_pos + 3'd1;
                end
            end
            PH_WIDTH, PH_HEIGHT: begin
                if (field_end) begin
                    want = (phase == PH_WIDTH) ? 64'(exp_width) : 64'(exp_height);
                    if (!side_ok(want[SIDE_W-1:0]) || field_acc != want)
                        hdr_bad = 1'b1;
                    phase = (phase == PH_WIDTH) ? PH_HEIGHT : PH_SEQ;
                end
            end
            PH_SEQ: begin
                if (field_end) begin
                    seq_held = field_acc;
                    phase    = PH_PALETTE;
                end
            end
            PH_PALETTE: begin
                if (field_end) begin
                    if (exp_palette == 0 || field_acc != 64'(exp_palette))
                        hdr_bad = 1'b1;
                    phase = PH_RUNS;
                end
            end
            PH_RUNS: begin
                if (field_end) begin
                    runs_left = field_acc[31:0];
                    if (hdr_bad) begin
                        push_status(ST_MISMATCH);
                        decided = 1'b1;
                    end else if (runs_left == 0) begin
                        push_total_status();
                        decided = 1'b1;
                    end else begin
                        phase = PH_RUNCOL;
                    end
                end
            end
            PH_RUNCOL: begin
                color_held = b;
                field_pos  = '0;
                phase      = PH_RUNCNT;
            end
            PH_RUNCNT: begin
                if (field_end) begin
                    cnt = field_acc[31:0];
                    if (color_held >= exp_palette) begin
                        push_status(ST_COLOR);
                        decided = 1'b1;
                    end else if (pixels_total + 64'(cnt) > canvas_area()) begin
                        push_status(ST_OVERFLOW);
                        decided = 1'b1;
                    end else begin
                        r = '0;
                        r.kind       = KIND_RUN;
                        r.run_color  = color_held;
                        r.run_length = cnt;
                        map_records_due.insert(map_records_due.size(), r);
                        pixels_total = pixels_total + 64'(cnt);
                        runs_left    = runs_left - 32'd1;
                        if (runs_left == 0) begin
                            push_total_status();
                            decided = 1'b1;
                        end else begin
                            phase = PH_RUNCOL;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (decided)
            phase = PH_DONE;

        // close the file: report truncation if nothing was decided
        if (fin) begin
            if (phase != PH_DONE)
                push_status(ST_TRUNCATED);
            clear_parse();
        end
    endtask

    // Compare one delivered result beat with the oldest prediction
    task automatic check_result(input rlmp_out_t got);
        rlmp_out_t want;
        if (map_records_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: unexpected result beat kind %0d colour %0d length %0d seq %h status %0d last %0d",
                         $time, got.kind, got.run_color, got.run_length,
                         got.loaded_sequence, got.status, got.last);
            return;
        end
        want = map_records_due.pop_front();
        checked++;
        if (got.kind !== want.kind || got.run_color !== want.run_color ||
            got.run_length !== want.run_length ||
            got.loaded_sequence !== want.loaded_sequence ||
            got.status !== want.status || got.last !== want.last) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("%0t: result mismatch, expected kind %0d colour %0d length %0d seq %h status %0d last %0d",
                         $time, want.kind, want.run_color, want.run_length,
                         want.loaded_sequence, want.status, want.last);
                $display("%0t:                  got      kind %0d colour %0d length %0d seq %h status %0d last %0d",
                         $time, got.kind, got.run_color, got.run_length,
                         got.loaded_sequence, got.status, got.last);
            end
        end
    endtask

    // Sample every port at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            exp_width   = MAP_WIDTH_RST;
            exp_height  = MAP_HEIGHT_RST;
            exp_palette = PAL_COUNT_RST;
            clear_parse();
            map_records_due.delete();
        end else begin
            // check the result beat first: it can never belong to a byte taken at this edge
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  exp_width   = cfg_data[SIDE_W-1:0];
                    CFG_MAP_HEIGHT: exp_height  = cfg_data[SIDE_W-1:0];
                    CFG_PAL_COUNT:  exp_palette = cfg_data[PAL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                parse_map_byte(s_data.data_byte, s_data.final_byte);
        end
        fail_count    <= fails;
        due_count     <= map_records_due.size();
        beats_checked <= checked;
    end

endmodule

FILE: tb/tb_run_length_map_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_map_parser_unit
// Feeds the run-length map parser with pixel-map files, one byte per beat:
// a few hand-made cases first, then files built from the current register
// setting, two in five well formed with random content, the rest carrying one
// flaw each (cut short, bad signature, header mismatch, colour out of range,
// pixel overflow, short total) or plain noise. The register setting and the
// idle pattern on both channels change between phases; a checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_run_length_map_parser_unit;
    import rlmp_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 8;
    localparam int NUM_SETTINGS      = 9;
    localparam int ITEMS_PER_SETTING = 115;
    localparam int BUSY_PCT          = 46;
    localparam int BOTH_BUSY_PCT     = 16;
    localparam int TIMEOUT_NS        = 2_000_000;

    // Index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_TRUNCATE,
        FLAW_MAGIC,
        FLAW_WIDTH,
        FLAW_HEIGHT,
        FLAW_PALETTE,
        FLAW_COLOR,
        FLAW_OVERFLOW,
        FLAW_SHORT,
        FLAW_NOISE
    } file_flaw_e;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    rlmp_in_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    rlmp_out_t         m_data;
    logic              cfg_we    = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    int fail_count;
    int due_count;
    int beats_checked;

    // Register values the next file is built against
    logic [SIDE_W-1:0] cur_w = MAP_WIDTH_RST;
    logic [SIDE_W-1:0] cur_h = MAP_HEIGHT_RST;
    logic [PAL_W-1:0]  cur_p = PAL_COUNT_RST;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int files_sent     = 0;

    logic [7:0] file_bytes [$];

    run_length_map_parser_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rlmp_stream_checker stream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .beats_checked (beats_checked)
    );

    always #CLK_HALF aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Present one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rlmp_in_t'({b, fin});
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Hold off the sender until every predicted result has been delivered
    task automatic drain_inputs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // Load register setting number idx; settings 1, 2, 4, 5 and 7 are extremes
    task automatic apply_setting(input int idx);
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [PAL_W-1:0]  p;
        logic [4:0]        pal_high;
        pal_high = '0;
        case (idx)
            1: begin
                w = 13'd4096; h = 13'd4096; p = 8'd255;
            end
            2: begin
                w = 13'd1; h = 13'd4096; p = 8'd1;
            end
            4: begin
                w = 13'd0; h = 13'd5; p = 8'd16;
            end
            5: begin
                w = 13'd8191; h = 13'd4097; p = 8'd0;
            end
            6: begin
                w = 13'($urandom_range(1, 64));
                h = 13'($urandom_range(1, 64));
                p = 8'($urandom_range(2, 32));
                pal_high = 5'($urandom_range(1, 31));
            end
            7: begin
                w = 13'd4096; h = 13'd1; p = 8'($urandom_range(1, 255));
            end
            default: begin
                w = 13'($urandom_range(1, 64));
                h = 13'($urandom_range(1, 64));
                p = 8'($urandom_range(2, 32));
            end
        endcase
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_PAL_COUNT, {pal_high, p});
        if (idx == 5)
            write_reg(CFG_UNUSED, 13'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_w = w;
        cur_h = h;
        cur_p = p;
    endtask

    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.insert(file_bytes.size(), v[8*i +: 8]);
    endtask

    function automatic file_flaw_e pick_flaw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return FLAW_NONE;
        if (r < 50) return FLAW_TRUNCATE;
        if (r < 56) return FLAW_MAGIC;
        if (r < 62) return FLAW_WIDTH;
        if (r < 67) return FLAW_HEIGHT;
        if (r < 72) return FLAW_PALETTE;
        if (r < 80) return FLAW_COLOR;
        if (r < 88) return FLAW_OVERFLOW;
        if (r < 95) return FLAW_SHORT;
        return FLAW_NOISE;
    endfunction

    // Build a file for the current setting, carrying at most one flaw
    task automatic build_map_file(input file_flaw_e flaw);
        logic [63:0] fw;
        logic [63:0] fh;
        logic [31:0] fpal;
        logic [31:0] area;
        logic [31:0] left;
        logic [31:0] c;
        logic [7:0]  colors [$];
        logic [31:0] counts [$];
        int          nruns;
        int          k;
        int          keep;
        file_bytes.delete();
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 12)) file_bytes.insert(file_bytes.size(), 8'($urandom));
            return;
        end

        for (int i = 0; i < 8; i++)
            file_bytes.insert(file_bytes.size(), MAGIC_BYTES[i]);
        if (flaw == FLAW_MAGIC)
            file_bytes[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);

        // header fields, one of them optionally off by one bit
        fw   = 64'(cur_w);
        fh   = 64'(cur_h);
        fpal = 32'(cur_p);
        if (flaw == FLAW_WIDTH)
            fw ^= 64'h1 << $urandom_range(0, 63);
        if (flaw == FLAW_HEIGHT)
            fh ^= 64'h1 << $urandom_range(0, 63);
        if (flaw == FLAW_PALETTE)
            fpal ^= 32'h1 << $urandom_range(0, 31);

        if (cur_w >= 1 && cur_w <= SIDE_MAX_DEF && cur_h >= 1 && cur_h <= SIDE_MAX_DEF)
            area = 32'(cur_w) * 32'(cur_h);
        else
            area = 32'd0;

        // split the canvas over the runs, with empty runs now and then
        nruns = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        if (flaw == FLAW_SHORT && $urandom_range(0, 3) == 0)
            nruns = 0;
        left = area;
        for (k = 0; k < nruns; k++) begin
            if (k == nruns - 1)
                c = left;
            else if ($urandom_range(0, 3) == 0)
                c = 32'd0;
            else
                c = $urandom_range(0, left);
            left = left - c;
            counts.insert(counts.size(), c);
            colors.insert(colors.size(),
                          (cur_p == 0) ? 8'd0 : 8'($urandom_range(0, cur_p - 1)));
        end

        if (nruns > 0) begin
            k = $urandom_range(0, nruns - 1);
            case (flaw)
                FLAW_COLOR: colors[k] = 8'($urandom_range(cur_p, 255));
                FLAW_OVERFLOW: begin
                    if ($urandom_range(0, 3) == 0)
                        counts[k] = 32'hFFFF_FFFF;
                    else
                        counts[k] = counts[k] + 32'($urandom_range(1, 1000));
                end
                FLAW_SHORT: begin
                    for (k = nruns - 1; k >= 0; k--) begin
                        if (counts[k] != 0) begin
                            counts[k] = $urandom_range(0, counts[k] - 1);
                            break;
                        end
                    end
                end
                default: ;
            endcase
        end

        put_le(fw, 8);
        put_le(fh, 8);
        put_le({$urandom, $urandom}, 8);
        put_le(64'(fpal), 4);
        put_le(64'(nruns), 4);
        for (k = 0; k < nruns; k++) begin
            file_bytes.insert(file_bytes.size(), colors[k]);
            put_le(64'(counts[k]), 4);
        end

        // cut the file short, or trail bytes past the decision
        if (flaw == FLAW_TRUNCATE) begin
            keep = $urandom_range(1, file_bytes.size() - 1);
            file_bytes = file_bytes[0:keep-1];
        end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) file_bytes.insert(file_bytes.size(), 8'($urandom));
        end
    endtask

    initial begin
        int phase_bytes;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // bad signature of all-ones bytes, then two ignored bytes
        file_bytes.delete();
        repeat (8) file_bytes.insert(file_bytes.size(), 8'hFF);
        repeat (2) file_bytes.insert(file_bytes.size(), 8'h00);
        send_file();
        // lone final byte
        file_bytes.delete();
        file_bytes.insert(file_bytes.size(), 8'h00);
        send_file();
        // intact signature that ends the file
        file_bytes.delete();
        for (int i = 0; i < 8; i++)
            file_bytes.insert(file_bytes.size(), MAGIC_BYTES[i]);
        send_file();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain_inputs();
            if (s > 0)
                apply_setting(s);
            case (s % 4)
                0: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = BUSY_PCT; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0; recv_stall_pct = BUSY_PCT;
                end
                default: begin
                    send_idle_pct = BOTH_BUSY_PCT; recv_stall_pct = BOTH_BUSY_PCT;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < ITEMS_PER_SETTING) begin
                build_map_file(pick_flaw());
                phase_bytes += file_bytes.size();
                send_file();
                // pause now and then until the block has caught up
                if ($urandom_range(0, 7) == 0)
                    drain_inputs();
            end
        end

        drain_inputs();
        $display("Sent %0d files, %0d bytes, over %0d register settings and four idle patterns.",
                 files_sent, bytes_sent, NUM_SETTINGS);
        $display("Checked %0d result beats against the predicted run and status stream.",
                 beats_checked);
        if (fail_count == 0 && due_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #TIMEOUT_NS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
src/rlmp_pkg.sv
src/rlmp_parser.sv
src/rlmp_result_fifo.sv
src/run_length_map_parser_unit.sv
tb/rlmp_stream_checker.sv
tb/tb_run_length_map_parser_unit.sv
